@@ src/imd_pkg.sv @@
package imd_pkg;

   localparam int CAPTURE_BYTES = 40;
   localparam int CAPTURE_IDX_W = $clog2(CAPTURE_BYTES);

   localparam logic [3:0] KIND_SYSTEM     = 4'd0;
   localparam logic [3:0] KIND_DIRECTORY  = 4'd1;
   localparam logic [3:0] KIND_ADD        = 4'd2;
   localparam logic [3:0] KIND_EXEC       = 4'd3;
   localparam logic [3:0] KIND_EXEC_PRICE = 4'd4;
   localparam logic [3:0] KIND_CANCEL     = 4'd5;
   localparam logic [3:0] KIND_DELETE     = 4'd6;
   localparam logic [3:0] KIND_REPLACE    = 4'd7;
   localparam logic [3:0] KIND_UNHANDLED  = 4'd8;

   localparam logic [7:0] TYPE_SYSTEM     = 8'h53;
   localparam logic [7:0] TYPE_DIRECTORY  = 8'h52;
   localparam logic [7:0] TYPE_ADD        = 8'h41;
   localparam logic [7:0] TYPE_ADD_MPID   = 8'h46;
   localparam logic [7:0] TYPE_EXEC       = 8'h45;
   localparam logic [7:0] TYPE_EXEC_PRICE = 8'h43;
   localparam logic [7:0] TYPE_CANCEL     = 8'h58;
   localparam logic [7:0] TYPE_DELETE     = 8'h44;
   localparam logic [7:0] TYPE_REPLACE    = 8'h55;

   localparam logic [7:0] SIDE_BUY        = 8'h42;
   localparam logic [7:0] PRINTABLE_YES   = 8'h59;

   typedef logic [CAPTURE_BYTES-1:0][7:0] capture_type;

   typedef struct packed {
      logic        pending;
      logic [15:0] length;
   } status_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] locate_code;
      logic [15:0] tracking_id;
      logic [47:0] timestamp_ns;
      logic [63:0] order_reference;
      logic [63:0] second_reference;
      logic [31:0] share_count;
      logic [31:0] price_value;
      logic [63:0] symbol_bytes;
      logic        flag_bit;
      logic [7:0]  code_byte;
      logic [15:0] body_length;
   } record_type;

endpackage

@@ src/itch_message_decoder.sv @@
// Decodes a stream of length-framed market-data messages arriving one byte per
// transfer and returns one record per complete message, held pending in the
// framer and then registered at the output. The block takes one byte every
// cycle; a byte is held off only when a finished message is waiting while the
// previous record is still stalled at the output register. Raising buffer_end
// on a byte drops any frame that is still open after that byte, and a
// zero-length frame yields an unhandled record with a type code of zero.
module itch_message_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_buffer_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_kind,
   output logic [15:0] rsp_locate_code,
   output logic [15:0] rsp_tracking_id,
   output logic [47:0] rsp_timestamp_ns,
   output logic [63:0] rsp_order_reference,
   output logic [63:0] rsp_second_reference,
   output logic [31:0] rsp_share_count,
   output logic [31:0] rsp_price_value,
   output logic [63:0] rsp_symbol_bytes,
   output logic        rsp_flag_bit,
   output logic [7:0]  rsp_code_byte,
   output logic [15:0] rsp_body_length
);
   import imd_pkg::*;

   status_type  status;
   capture_type capture;
   record_type  record;
   logic        take;

   imd_framer u_framer (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_buffer_end (req_buffer_end),
      .take           (take),
      .status         (status),
      .capture        (capture)
   );

   imd_decoder u_decoder (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .capture   (capture),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .record    (record)
   );

   assign rsp_kind             = record.kind;
   assign rsp_locate_code      = record.locate_code;
   assign rsp_tracking_id      = record.tracking_id;
   assign rsp_timestamp_ns     = record.timestamp_ns;
   assign rsp_order_reference  = record.order_reference;
   assign rsp_second_reference = record.second_reference;
   assign rsp_share_count      = record.share_count;
   assign rsp_price_value      = record.price_value;
   assign rsp_symbol_bytes     = record.symbol_bytes;
   assign rsp_flag_bit         = record.flag_bit;
   assign rsp_code_byte        = record.code_byte;
   assign rsp_body_length      = record.body_length;

endmodule

@@ src/imd_framer.sv @@
module imd_framer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_buffer_end,
   input  logic                 take,
   output imd_pkg::status_type  status,
   output imd_pkg::capture_type capture
);
   import imd_pkg::*;

   typedef enum logic [1:0] {
      PHASE_LEN_HIGH,
      PHASE_LEN_LOW,
      PHASE_BODY
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  length_high_ff, length_high_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] index_ff, index_in;
   capture_type capture_ff, capture_in;
   logic        pending_ff, pending_in;
   logic        accept;
   logic        complete;
   logic [15:0] index_next;

   assign req_stall = pending_ff & ~take;
   assign accept    = req_valid & ~req_stall;
   assign index_next = index_ff + 16'd1;

   always_comb begin
      phase_in       = phase_ff;
      length_high_in = length_high_ff;
      length_in      = length_ff;
      index_in       = index_ff;
      capture_in     = capture_ff;
      complete       = 1'b0;
      if (accept) begin
         case (phase_ff)
            PHASE_LEN_LOW: begin
               length_in  = {length_high_ff, req_data_byte};
               capture_in = '0;
               index_in   = '0;
               if (length_in == 16'd0) begin
                  complete = 1'b1;
                  phase_in = PHASE_LEN_HIGH;
               end else begin
                  phase_in = PHASE_BODY;
               end
            end
            PHASE_BODY: begin
               if (index_ff < 16'(CAPTURE_BYTES)) begin
                  capture_in[index_ff[CAPTURE_IDX_W-1:0]] = req_data_byte;
               end
               index_in = index_next;
               if (index_next == length_ff) begin
                  complete = 1'b1;
                  phase_in = PHASE_LEN_HIGH;
               end
            end
            default: begin
               length_high_in = req_data_byte;
               phase_in       = PHASE_LEN_LOW;
            end
         endcase
         if (req_buffer_end) begin
            phase_in = PHASE_LEN_HIGH;
         end
      end
      if (complete) begin
         pending_in = 1'b1;
      end else if (take) begin
         pending_in = 1'b0;
      end else begin
         pending_in = pending_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PHASE_LEN_HIGH;
         length_high_ff <= '0;
         length_ff      <= '0;
         index_ff       <= '0;
         capture_ff     <= '0;
         pending_ff     <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         length_high_ff <= length_high_in;
         length_ff      <= length_in;
         index_ff       <= index_in;
         capture_ff     <= capture_in;
         pending_ff     <= pending_in;
      end
   end

   assign status.pending = pending_ff;
   assign status.length  = length_ff;
   assign capture        = capture_ff;

endmodule

@@ src/imd_decoder.sv @@
module imd_decoder (
   input  logic                 clock,
   input  logic                 reset,
   input  imd_pkg::status_type  status,
   input  imd_pkg::capture_type capture,
   output logic                 take,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output imd_pkg::record_type  record
);
   import imd_pkg::*;

   record_type  record_ff, record_in;
   logic        valid_ff, valid_in;
   capture_type c;

   assign c    = capture;
   assign take = status.pending & (~valid_ff | ~rsp_stall);

   always_comb begin
      record_in = '0;
      record_in.body_length = status.length;
      if (status.length == 16'd0) begin
         record_in.kind = KIND_UNHANDLED;
      end else begin
         case (c[0])
            TYPE_SYSTEM: begin
               record_in.kind         = KIND_SYSTEM;
               record_in.timestamp_ns = {c[5], c[6], c[7], c[8], c[9], c[10]};
               record_in.code_byte    = c[11];
            end
            TYPE_DIRECTORY: begin
               record_in.kind         = KIND_DIRECTORY;
               record_in.locate_code  = {c[1], c[2]};
               record_in.timestamp_ns = {c[5], c[6], c[7], c[8], c[9], c[10]};
               record_in.symbol_bytes = {c[11], c[12], c[13], c[14],
                                         c[15], c[16], c[17], c[18]};
               record_in.code_byte    = c[19];
            end
            TYPE_ADD, TYPE_ADD_MPID: begin
               record_in.kind            = KIND_ADD;
               record_in.locate_code     = {c[1], c[2]};
               record_in.tracking_id     = {c[3], c[4]};
               record_in.timestamp_ns    = {c[5], c[6], c[7], c[8], c[9], c[10]};
               record_in.order_reference = {c[11], c[12], c[13], c[14],
                                            c[15], c[16], c[17], c[18]};
               record_in.flag_bit        = (c[19] == SIDE_BUY);
               record_in.share_count     = {c[20], c[21], c[22], c[23]};
               record_in.symbol_bytes    = {c[24], c[25], c[26], c[27],
                                            c[28], c[29], c[30], c[31]};
               record_in.price_value     = {c[32], c[33], c[34], c[35]};
            end
            TYPE_EXEC, TYPE_EXEC_PRICE: begin
               record_in.kind             = (c[0] == TYPE_EXEC) ? KIND_EXEC
                                                                : KIND_EXEC_PRICE;
               record_in.locate_code      = {c[1], c[2]};
               record_in.timestamp_ns     = {c[5], c[6], c[7], c[8], c[9], c[10]};
               record_in.order_reference  = {c[11], c[12], c[13], c[14],
                                             c[15], c[16], c[17], c[18]};
               record_in.share_count      = {c[19], c[20], c[21], c[22]};
               record_in.second_reference = {c[23], c[24], c[25], c[26],
                                             c[27], c[28], c[29], c[30]};
               if (c[0] == TYPE_EXEC_PRICE) begin
                  record_in.flag_bit    = (c[31] == PRINTABLE_YES);
                  record_in.price_value = {c[32], c[33], c[34], c[35]};
               end
            end
            TYPE_CANCEL: begin
               record_in.kind            = KIND_CANCEL;
               record_in.locate_code     = {c[1], c[2]};
               record_in.timestamp_ns    = {c[5], c[6], c[7], c[8], c[9], c[10]};
               record_in.order_reference = {c[11], c[12], c[13], c[14],
                                            c[15], c[16], c[17], c[18]};
               record_in.share_count     = {c[19], c[20], c[21], c[22]};
            end
            TYPE_DELETE: begin
               record_in.kind            = KIND_DELETE;
               record_in.locate_code     = {c[1], c[2]};
               record_in.timestamp_ns    = {c[5], c[6], c[7], c[8], c[9], c[10]};
               record_in.order_reference = {c[11], c[12], c[13], c[14],
                                            c[15], c[16], c[17], c[18]};
            end
            TYPE_REPLACE: begin
               record_in.kind             = KIND_REPLACE;
               record_in.locate_code      = {c[1], c[2]};
               record_in.timestamp_ns     = {c[5], c[6], c[7], c[8], c[9], c[10]};
               record_in.order_reference  = {c[11], c[12], c[13], c[14],
                                             c[15], c[16], c[17], c[18]};
               record_in.second_reference = {c[19], c[20], c[21], c[22],
                                             c[23], c[24], c[25], c[26]};
               record_in.share_count      = {c[27], c[28], c[29], c[30]};
               record_in.price_value      = {c[31], c[32], c[33], c[34]};
            end
            default: begin
               record_in.kind      = KIND_UNHANDLED;
               record_in.code_byte = c[0];
            end
         endcase
      end
   end

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (~rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         record_ff <= record_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign record    = record_ff;

endmodule
